### hdl/itp_pkg.sv
package itp_pkg;

    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_UNMATCH  = 2'd2;

    typedef logic [1:0] t_stk_op;

    localparam t_stk_op STK_HOLD = 2'd0;
    localparam t_stk_op STK_PUSH = 2'd1;
    localparam t_stk_op STK_POP  = 2'd2;

    typedef struct packed {
        t_stk_op           op;
        logic [CHAR_W-1:0] data;
    } t_stk_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] top;
        logic              empty;
        logic              full;
    } t_stk_stat;

    function automatic logic [1:0] f_prec(input logic [CHAR_W-1:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_ADD || c == CH_SUB) begin
            p = 2'd1;
        end else if (c == CH_MUL || c == CH_DIV) begin
            p = 2'd2;
        end else if (c == CH_POW) begin
            p = 2'd3;
        end
        return p;
    endfunction

endpackage

### hdl/infix_to_postfix_converter.sv
// Converts an infix expression, one ASCII character per input transaction, into postfix
// characters on the output stream. The operator stack is a row of STACK_DEPTH cells whose
// top always sits in the first cell, so a push or pop shifts every cell by one place, all
// cells at once. Input transactions are taken one at a time: an item occupies the block
// through its own step, a step for each operator popped, at the end of an expression a
// step for each stacked entry being drained plus one more, and a flush of the held output;
// output back-pressure stalls these steps. Each output transaction is held back until the
// next one of the same input item is known, so that the last one of an input item can be
// flagged on tlast. An overflowing push or a close parenthesis with no open one yields a
// character-less transaction carrying an error code in tuser.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_char
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_char
    output logic        o_m_axis_tlast,
    output logic [3:0]  o_m_axis_tuser    // [0] has_char, [1] expr_done, [3:2] error_code
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHAR  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CHAR_W-1:0] r_char;
    logic              r_fin;
    logic              r_emitted;

    logic              r_pend_valid;
    logic [CHAR_W-1:0] r_pend_char;
    logic              r_pend_has;
    logic [1:0]        r_pend_err;

    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_has;
    logic              r_o_last;
    logic              r_o_done;
    logic [1:0]        r_o_err;

    t_stk_cmd          w_cmd;
    t_stk_stat         w_stat;

    logic              w_out_free;
    logic              w_accept;
    logic              w_res;
    logic [CHAR_W-1:0] w_res_char;
    logic              w_res_has;
    logic [1:0]        w_res_err;
    logic              w_flush;
    logic [1:0]        w_prec;
    logic              w_pop_op;
    logic [1:0]        w_after;

    itp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    assign w_out_free = !r_o_valid || i_m_axis_tready;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_prec     = f_prec(r_char);
    assign w_pop_op   = !w_stat.empty && (w_prec <= f_prec(w_stat.top));
    assign w_after    = r_fin ? S_DRAIN : S_FLUSH;

    always_comb begin
        n_state    = r_state;
        w_cmd.op   = STK_HOLD;
        w_cmd.data = r_char;
        w_res      = 1'b0;
        w_res_char = '0;
        w_res_has  = 1'b0;
        w_res_err  = ERR_NONE;
        w_flush    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                if (w_out_free) begin
                    if (r_char == CH_CLOSE) begin
                        if (!w_stat.empty && w_stat.top != CH_OPEN) begin
                            w_cmd.op   = STK_POP;
                            w_res      = 1'b1;
                            w_res_char = w_stat.top;
                            w_res_has  = 1'b1;
                        end else if (w_stat.empty) begin
                            w_res     = 1'b1;
                            w_res_err = ERR_UNMATCH;
                            n_state   = w_after;
                        end else begin
                            w_cmd.op = STK_POP;
                            n_state  = w_after;
                        end
                    end else if (r_char != CH_OPEN && w_prec == 2'd0) begin
                        w_res      = 1'b1;
                        w_res_char = r_char;
                        w_res_has  = 1'b1;
                        n_state    = w_after;
                    end else if (r_char != CH_OPEN && w_pop_op) begin
                        w_cmd.op   = STK_POP;
                        w_res      = 1'b1;
                        w_res_char = w_stat.top;
                        w_res_has  = 1'b1;
                    end else begin
                        if (!w_stat.full) begin
                            w_cmd.op = STK_PUSH;
                        end else begin
                            w_res     = 1'b1;
                            w_res_err = ERR_OVERFLOW;
                        end
                        n_state = w_after;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    if (!w_stat.empty) begin
                        w_cmd.op   = STK_POP;
                        w_res      = 1'b1;
                        w_res_char = w_stat.top;
                        w_res_has  = 1'b1;
                    end else begin
                        w_res   = !r_emitted;
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_emitted    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_emitted <= 1'b0;
            end else if (w_res) begin
                r_emitted <= 1'b1;
            end
            if (w_res) begin
                r_pend_valid <= 1'b1;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_o_valid <= (w_res && r_pend_valid) || w_flush;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_s_axis_tdata;
            r_fin  <= i_s_axis_tlast;
        end
        if (w_res) begin
            r_pend_char <= w_res_char;
            r_pend_has  <= w_res_has;
            r_pend_err  <= w_res_err;
        end
        if (w_out_free) begin
            r_o_char <= r_pend_char;
            r_o_has  <= r_pend_has;
            r_o_err  <= r_pend_err;
            r_o_last <= w_flush;
            r_o_done <= w_flush && r_fin;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_char;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = {r_o_err, r_o_done, r_o_has};

endmodule

### hdl/itp_cell.sv
module itp_cell
    import itp_pkg::*;
(
    input  logic              i_clk,
    input  t_stk_op           i_op,
    input  logic [CHAR_W-1:0] i_from_above,
    input  logic [CHAR_W-1:0] i_from_below,
    output logic [CHAR_W-1:0] o_data
);

    logic [CHAR_W-1:0] r_data;
    logic [CHAR_W-1:0] n_data;

    always_comb begin
        unique case (i_op)
            STK_PUSH: n_data = i_from_above;
            STK_POP:  n_data = i_from_below;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### hdl/itp_stack.sv
module itp_stack
    import itp_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stk_cmd  i_cmd,
    output t_stk_stat o_stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CHAR_W-1:0] w_data [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [CHAR_W-1:0] w_above;
            logic [CHAR_W-1:0] w_below;
            if (g == 0) begin : g_head
                assign w_above = i_cmd.data;
            end else begin : g_body
                assign w_above = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_below = '0;
            end else begin : g_link
                assign w_below = w_data[g+1];
            end
            itp_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (i_cmd.op),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_data       (w_data[g])
            );
        end
    endgenerate

    always_comb begin
        unique case (i_cmd.op)
            STK_PUSH: n_count = r_count + CNT_W'(1);
            STK_POP:  n_count = r_count - CNT_W'(1);
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.top   = w_data[0];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

endmodule

### hdl/itp_checker.sv
module itp_checker
    import itp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic [3:0] o_m_axis_tuser
);

    // The end of an expression is always the last transaction of its input item.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tlast)
        else $error("expr_done without tlast");

    // A transaction that carries a character never carries an error.
    a_char_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tuser[3:2] == ERR_NONE)
        else $error("character transaction with error code");

    // A status-only transaction carries a zero character.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 8'h00)
        else $error("status transaction with nonzero character");

    // Input items are handled one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output transaction changed");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

### sim/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
    import itp_pkg::*;

    localparam int STACK_DEPTH  = 32;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 16;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
        logic       done;
        logic [1:0] err;
    } t_postfix_sym;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoe;
    } t_char_item;

    typedef struct packed {
        logic [7:0]   ch;
        logic         eoe;
        logic [7:0]   reps;
        logic         typed;
        t_postfix_sym sym;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;    // [7:0] in_char
    logic       i_s_axis_tlast = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [7:0] out_char
    logic       o_m_axis_tlast;
    logic [3:0] o_m_axis_tuser;            // [0] has_char, [1] expr_done, [3:2] error_code

    logic [7:0]   op_stk [STACK_DEPTH];
    int           stk_cnt = 0;
    t_postfix_sym step_q[$];
    t_postfix_sym postfix_q[$];
    t_char_item   plan_q[$];
    t_dir_row     dir_q[$];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int rx_hold = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int idle_cyc = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_ovf = 0;
    int n_unm = 0;
    int n_errs = 0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [1:0] op_rank(input logic [7:0] c);
        case (c)
            CH_ADD, CH_SUB: return 2'd1;
            CH_MUL, CH_DIV: return 2'd2;
            CH_POW:         return 2'd3;
            default:        return 2'd0;
        endcase
    endfunction

    task automatic emit_sym(input logic [7:0] ch, input logic has, input logic [1:0] err);
        t_postfix_sym s;
        s.ch   = ch;
        s.has  = has;
        s.last = 1'b0;
        s.done = 1'b0;
        s.err  = err;
        step_q.push_back(s);
    endtask

    task automatic pop_sym();
        stk_cnt--;
        emit_sym(op_stk[stk_cnt], 1'b1, ERR_NONE);
    endtask

    task automatic push_op(input logic [7:0] c);
        if (stk_cnt < STACK_DEPTH) begin
            op_stk[stk_cnt] = c;
            stk_cnt++;
        end else begin
            emit_sym(8'h00, 1'b0, ERR_OVERFLOW);
        end
    endtask

    task automatic convert_char(input logic [7:0] ch, input logic eoe);
        logic [1:0]   rank;
        t_postfix_sym s;
        step_q.delete();
        if (ch == CH_OPEN) begin
            push_op(ch);
        end else if (ch == CH_CLOSE) begin
            while (stk_cnt > 0 && op_stk[stk_cnt-1] != CH_OPEN) pop_sym();
            if (stk_cnt == 0) begin
                emit_sym(8'h00, 1'b0, ERR_UNMATCH);
            end else begin
                stk_cnt--;
            end
        end else begin
            rank = op_rank(ch);
            if (rank == 2'd0) begin
                emit_sym(ch, 1'b1, ERR_NONE);
            end else begin
                while (stk_cnt > 0 && rank <= op_rank(op_stk[stk_cnt-1])) pop_sym();
                push_op(ch);
            end
        end
        if (eoe) begin
            while (stk_cnt > 0) pop_sym();
            if (step_q.size() == 0) emit_sym(8'h00, 1'b0, ERR_NONE);
        end
        if (step_q.size() > 0) begin
            s = step_q.pop_back();
            s.last = 1'b1;
            s.done = eoe;
            step_q.push_back(s);
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic eoe);
        @(negedge i_clk);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= eoe;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
    endtask

    task automatic take_item(input logic [7:0] ch, input logic eoe, input logic typed,
                             input t_postfix_sym sym);
        int i;
        send_char(ch, eoe);
        convert_char(ch, eoe);
        if (typed) begin
            postfix_q.push_back(sym);
        end else begin
            for (i = 0; i < step_q.size(); i++) postfix_q.push_back(step_q[i]);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (postfix_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic eoe, input int reps);
        t_dir_row r;
        r = '0;
        r.ch   = ch;
        r.eoe  = eoe;
        r.reps = 8'(reps);
        dir_q.push_back(r);
    endtask

    task automatic add_checked(input logic [7:0] ch, input logic eoe, input logic [7:0] o_ch,
                               input logic has, input logic done, input logic [1:0] err);
        t_dir_row r;
        r.ch       = ch;
        r.eoe      = eoe;
        r.reps     = 8'd1;
        r.typed    = 1'b1;
        r.sym.ch   = o_ch;
        r.sym.has  = has;
        r.sym.last = 1'b1;
        r.sym.done = done;
        r.sym.err  = err;
        dir_q.push_back(r);
    endtask

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(9) < 6) return 8'h61 + 8'($urandom_range(25));
        c = 8'($urandom_range(255));
        while (c == CH_OPEN || c == CH_CLOSE || op_rank(c) != 2'd0) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(4))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    task automatic plan_char(input logic [7:0] c);
        t_char_item it;
        it.ch  = c;
        it.eoe = 1'b0;
        plan_q.push_back(it);
    endtask

    task automatic build_expr();
        int         n_terms;
        int         depth;
        int         k;
        t_char_item it;
        plan_q.delete();
        depth = 0;
        if ($urandom_range(14) == 0) begin
            for (k = 0; k < STACK_DEPTH + 2; k++) plan_char(CH_OPEN);
            plan_char(pick_operand());
        end else begin
            n_terms = $urandom_range(1, 6);
            for (k = 0; k < n_terms; k++) begin
                if (k > 0) plan_char(pick_operator());
                while (depth < 4 && $urandom_range(3) == 0) begin
                    plan_char(CH_OPEN);
                    depth++;
                end
                plan_char(pick_operand());
                while (depth > 0 && $urandom_range(2) == 0) begin
                    plan_char(CH_CLOSE);
                    depth--;
                end
            end
            while (depth > 0 && $urandom_range(4) != 0) begin
                plan_char(CH_CLOSE);
                depth--;
            end
            if ($urandom_range(7) == 0) plan_char(CH_CLOSE);
            if ($urandom_range(9) == 0) void'(plan_q.pop_front());
        end
        if (plan_q.size() == 0) plan_char(pick_operand());
        it = plan_q.pop_back();
        it.eoe = 1'b1;
        plan_q.push_back(it);
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int exp_v);
        n_errs++;
        $display("MISMATCH at output %0d: %s got 0x%0h, expected 0x%0h",
                 n_results, what, got_v, exp_v);
    endtask

    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            i_m_axis_tready <= 1'b0;
            rx_hold <= HOLD_CYCLES - 1;
        end else if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_postfix_sym got;
        t_postfix_sym want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.ch   = o_m_axis_tdata;
            got.has  = o_m_axis_tuser[0];
            got.last = o_m_axis_tlast;
            got.done = o_m_axis_tuser[1];
            got.err  = o_m_axis_tuser[3:2];
            if (got.err == ERR_OVERFLOW) n_ovf++;
            if (got.err == ERR_UNMATCH) n_unm++;
            if (postfix_q.size() == 0) begin
                report_mismatch("unexpected transaction, out_char", got.ch, 0);
            end else begin
                want = postfix_q.pop_front();
                if (got.ch !== want.ch) report_mismatch("out_char", got.ch, want.ch);
                if (got.has !== want.has) report_mismatch("has_char", got.has, want.has);
                if (got.last !== want.last) report_mismatch("run_last", got.last, want.last);
                if (got.done !== want.done) report_mismatch("expr_done", got.done, want.done);
                if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cyc >= IDLE_LIMIT);
        $display("Timeout: no transaction for %0d cycles, %0d results still pending.",
                 IDLE_LIMIT, postfix_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_dir_row     row;
        t_char_item   it;
        t_postfix_sym no_sym;
        int           r;
        int           k;
        int           ph;
        int           quota;
        no_sym = '0;

        add_checked("a", 1'b1, "a", 1'b1, 1'b1, ERR_NONE);
        add_checked(8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
        add_checked(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0, ERR_NONE);
        add_checked(CH_CLOSE, 1'b0, 8'h00, 1'b0, 1'b0, ERR_UNMATCH);
        add_row(CH_OPEN, 1'b0, 1);
        add_checked(CH_CLOSE, 1'b1, 8'h00, 1'b0, 1'b1, ERR_NONE);
        add_row("a", 1'b0, 1);
        add_row(CH_ADD, 1'b0, 1);
        add_row("b", 1'b0, 1);
        add_row(CH_MUL, 1'b0, 1);
        add_row("c", 1'b0, 1);
        add_row(CH_POW, 1'b0, 1);
        add_row("d", 1'b0, 1);
        add_row(CH_SUB, 1'b0, 1);
        add_row(CH_OPEN, 1'b0, 1);
        add_row("f", 1'b0, 1);
        add_row(CH_DIV, 1'b0, 1);
        add_row("g", 1'b0, 1);
        add_row(CH_CLOSE, 1'b1, 1);
        add_row(CH_ADD, 1'b0, 1);
        add_row(CH_CLOSE, 1'b0, 1);
        add_row(CH_OPEN, 1'b0, 1);
        add_row("x", 1'b1, 1);
        add_row(CH_OPEN, 1'b0, STACK_DEPTH);
        add_checked(CH_OPEN, 1'b0, 8'h00, 1'b0, 1'b0, ERR_OVERFLOW);
        add_row("z", 1'b1, 1);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < dir_q.size(); r++) begin
            row = dir_q[r];
            for (k = 0; k < row.reps; k++) begin
                take_item(row.ch, row.eoe, row.typed && (k == row.reps - 1), row.sym);
            end
        end
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
                default: begin snd_idle_pct = 35; rcv_stall_pct = 35; end
            endcase
            quota = n_sent + PHASE_ITEMS;
            while (n_sent < quota) begin
                if ($urandom_range(5) == 0) begin
                    take_item(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, no_sym);
                end else begin
                    build_expr();
                    while (plan_q.size() > 0) begin
                        it = plan_q.pop_front();
                        take_item(it.ch, it.eoe, 1'b0, no_sym);
                    end
                end
            end
            wait_drained();
        end

        // The consumer holds off for a long stretch while a long operator chain is offered.
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_req = !hold_req;
        for (k = 0; k < 12; k++) begin
            take_item(pick_operand(), 1'b0, 1'b0, no_sym);
            take_item(pick_operator(), 1'b0, 1'b0, no_sym);
        end
        take_item(pick_operand(), 1'b1, 1'b0, no_sym);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Fed %0d infix characters through directed, random and back-pressure runs.",
                 n_sent);
        $display("Checked %0d postfix transactions, %0d overflow and %0d unmatched flags.",
                 n_results, n_ovf, n_unm);
        if (n_errs == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### infix_to_postfix_converter.f
hdl/itp_pkg.sv
hdl/itp_cell.sv
hdl/itp_stack.sv
hdl/infix_to_postfix_converter.sv
hdl/itp_checker.sv
sim/infix_to_postfix_converter_tb.sv
